@@ design/dlts_pkg.sv @@
// shared types and constants for the delta list task scheduler
package dlts_pkg;

    localparam int ID_W   = 8;
    localparam int TIME_W = 32;
    localparam int SUM_W  = TIME_W + 1;
    localparam int ALU_W  = TIME_W + 2;
    localparam int IN_W   = 72;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_ADD      = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_DELETE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] rel_delay;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TICK_UPD,
        S_DSP_RD,
        S_RM_RD,
        S_RM_WR,
        S_INS_START,
        S_WALK_SUM,
        S_WALK_CMP,
        S_INS_REL,
        S_INS_SH_RD,
        S_INS_SH_WR,
        S_INS_PUT,
        S_FINISH
    } state_t;

endpackage

@@ design/dlts_alu.sv @@
// shared add / subtract unit used by the tick, walk and insert steps of the sequencer
module dlts_alu
(
    input  dlts_pkg::alu_op_t           op,
    input  logic [dlts_pkg::SUM_W-1:0]  a,
    input  logic [dlts_pkg::SUM_W-1:0]  b,
    output logic [dlts_pkg::ALU_W-1:0]  result
);

    always_comb
    begin
        case (op)
            dlts_pkg::ALU_SUB: result = {1'b0, a} - {1'b0, b};
            dlts_pkg::ALU_ADD: result = {1'b0, a} + {1'b0, b};
            default:           result = {1'b0, a} + {1'b0, b};
        endcase
    end

endmodule

@@ design/dlts_entry_ram.sv @@
// task entry storage, one write and one registered read per cycle
module dlts_entry_ram
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  dlts_pkg::entry_t    wdata,
    input  logic                re,
    input  logic [ADDR_W-1:0]   raddr,
    output dlts_pkg::entry_t    rdata
);

    dlts_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds when no read is issued
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/delta_list_task_scheduler_unit.sv @@
// top level: sequencer walking a delta list held in an entry ram with one write and one read port
// throughput: one word at a time, the next taken in the cycle after the result is loaded;
// a finished result waits until the output register is free (m_tvalid low or m_tready high);
// reset: asynchronous active low, empties the list, clears head ready and output valid
module delta_list_task_scheduler_unit
#(
    parameter int MAX_TASKS = 16,
    localparam int IDX_W = $clog2(MAX_TASKS),
    localparam int CNT_W = $clog2(MAX_TASKS + 1),
    localparam int OUT_W = ((dlts_pkg::ID_W + 2 + CNT_W + 7) / 8) * 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [dlts_pkg::IN_W-1:0]  s_tdata,  // task_id, delay, period
    input  logic [1:0]                 s_tuser,  // operation
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_W-1:0]           m_tdata,  // run_task_id, status, task_count
    output logic                       m_tuser   // dispatched
);

    localparam int ST_LSB  = dlts_pkg::ID_W;
    localparam int CNT_LSB = dlts_pkg::ID_W + 2;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);

    dlts_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             head_ready_reg, head_ready_next;
    logic             m_tvalid_reg, m_tvalid_next;

    dlts_pkg::op_t                 op_reg, op_next;
    logic [dlts_pkg::ID_W-1:0]     ins_id_reg, ins_id_next;
    logic [dlts_pkg::TIME_W-1:0]   ins_d_reg, ins_d_next;
    logic [dlts_pkg::TIME_W-1:0]   ins_per_reg, ins_per_next;
    logic [dlts_pkg::SUM_W-1:0]    cum_reg, cum_next;
    logic [dlts_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [dlts_pkg::TIME_W-1:0]   rel_new_reg, rel_new_next;
    logic [IDX_W-1:0]              pos_reg, pos_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic                          disp_reg, disp_next;
    logic [dlts_pkg::ID_W-1:0]     run_id_reg, run_id_next;
    dlts_pkg::status_t             status_reg, status_next;
    logic [OUT_W-1:0]              m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;

    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    dlts_pkg::entry_t              ram_wdata;
    logic                          ram_re;
    logic [IDX_W-1:0]              ram_raddr;
    dlts_pkg::entry_t              ram_rdata;

    dlts_pkg::alu_op_t             alu_op;
    logic [dlts_pkg::SUM_W-1:0]    alu_a;
    logic [dlts_pkg::SUM_W-1:0]    alu_b;
    logic [dlts_pkg::ALU_W-1:0]    alu_result;

    logic walk_more;
    logic rm_more;
    logic out_free;
    logic ins_found;

    dlts_entry_ram
    #(
        .DEPTH  (MAX_TASKS),
        .ADDR_W (IDX_W)
    )
    u_ram
    (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .re     (ram_re),
        .raddr  (ram_raddr),
        .rdata  (ram_rdata)
    );

    dlts_alu u_alu
    (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_result)
    );

    assign walk_more = (CNT_W'(pos_reg) + CNT_W'(1)) < count_reg;
    assign rm_more   = (CNT_W'(idx_reg) + CNT_W'(1)) < count_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    // borrow of delay minus running sum: new task goes before this entry
    assign ins_found = alu_result[dlts_pkg::ALU_W-1];

    assign s_tready = (state_reg == dlts_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dlts_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = dlts_pkg::S_DECODE;
                end
            end
            dlts_pkg::S_DECODE:
            begin
                case (op_reg)
                    dlts_pkg::OP_TICK:
                        state_next = (count_reg != '0) ? dlts_pkg::S_TICK_UPD
                                                       : dlts_pkg::S_FINISH;
                    dlts_pkg::OP_ADD:
                        state_next = (count_reg == MAX_CNT) ? dlts_pkg::S_FINISH
                                                            : dlts_pkg::S_INS_START;
                    dlts_pkg::OP_DISPATCH:
                        state_next = (count_reg != '0 && head_ready_reg) ?
                                     dlts_pkg::S_DSP_RD : dlts_pkg::S_FINISH;
                    dlts_pkg::OP_DELETE:
                        state_next = (count_reg == '0) ? dlts_pkg::S_FINISH
                                                       : dlts_pkg::S_RM_RD;
                    default:
                        state_next = dlts_pkg::S_FINISH;
                endcase
            end
            dlts_pkg::S_TICK_UPD:  state_next = dlts_pkg::S_FINISH;
            dlts_pkg::S_DSP_RD:    state_next = dlts_pkg::S_RM_RD;
            dlts_pkg::S_RM_RD:
            begin
                if (rm_more)
                begin
                    state_next = dlts_pkg::S_RM_WR;
                end
                else if (op_reg == dlts_pkg::OP_DISPATCH && ins_per_reg != '0)
                begin
                    state_next = dlts_pkg::S_INS_START;
                end
                else
                begin
                    state_next = dlts_pkg::S_FINISH;
                end
            end
            dlts_pkg::S_RM_WR:     state_next = dlts_pkg::S_RM_RD;
            dlts_pkg::S_INS_START:
                state_next = (count_reg != '0) ? dlts_pkg::S_WALK_SUM : dlts_pkg::S_INS_REL;
            dlts_pkg::S_WALK_SUM:  state_next = dlts_pkg::S_WALK_CMP;
            dlts_pkg::S_WALK_CMP:
                state_next = (!ins_found && walk_more) ? dlts_pkg::S_WALK_SUM
                                                       : dlts_pkg::S_INS_REL;
            dlts_pkg::S_INS_REL:   state_next = dlts_pkg::S_INS_SH_RD;
            dlts_pkg::S_INS_SH_RD:
                state_next = (idx_reg > pos_reg) ? dlts_pkg::S_INS_SH_WR
                                                 : dlts_pkg::S_INS_PUT;
            dlts_pkg::S_INS_SH_WR: state_next = dlts_pkg::S_INS_SH_RD;
            dlts_pkg::S_INS_PUT:   state_next = dlts_pkg::S_FINISH;
            dlts_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = dlts_pkg::S_IDLE;
                end
            end
            default:               state_next = dlts_pkg::S_IDLE;
        endcase
    end

    // datapath, ram and alu control
    always_comb
    begin
        count_next      = count_reg;
        head_ready_next = head_ready_reg;
        op_next         = op_reg;
        ins_id_next     = ins_id_reg;
        ins_d_next      = ins_d_reg;
        ins_per_next    = ins_per_reg;
        cum_next        = cum_reg;
        sum_next        = sum_reg;
        rel_new_next    = rel_new_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        disp_next       = disp_reg;
        run_id_next     = run_id_reg;
        status_next     = status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = '0;

        alu_op = dlts_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;

        case (state_reg)
            dlts_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next      = dlts_pkg::op_t'(s_tuser);
                    ins_id_next  = s_tdata[7:0];
                    ins_d_next   = s_tdata[39:8];
                    ins_per_next = s_tdata[71:40];
                    disp_next    = 1'b0;
                    run_id_next  = '0;
                    status_next  = dlts_pkg::ST_OK;
                end
            end
            dlts_pkg::S_DECODE:
            begin
                case (op_reg)
                    dlts_pkg::OP_TICK:
                    begin
                        ram_re = (count_reg != '0);
                    end
                    dlts_pkg::OP_ADD:
                    begin
                        if (count_reg == MAX_CNT)
                        begin
                            status_next = dlts_pkg::ST_FULL;
                        end
                    end
                    dlts_pkg::OP_DISPATCH:
                    begin
                        ram_re = (count_reg != '0) && head_ready_reg;
                    end
                    dlts_pkg::OP_DELETE:
                    begin
                        idx_next = '0;
                        if (count_reg == '0)
                        begin
                            status_next = dlts_pkg::ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        idx_next = '0;
                    end
                endcase
            end
            dlts_pkg::S_TICK_UPD:
            begin
                alu_op = dlts_pkg::ALU_SUB;
                alu_a  = {1'b0, ram_rdata.rel_delay};
                alu_b  = dlts_pkg::SUM_W'(1);
                if (ram_rdata.rel_delay == '0)
                begin
                    head_ready_next = 1'b1;
                    // periodic head reloads its delay
                    if (ram_rdata.period != '0)
                    begin
                        ram_we              = 1'b1;
                        ram_wdata.rel_delay = ram_rdata.period;
                    end
                end
                else
                begin
                    ram_we              = 1'b1;
                    ram_wdata.rel_delay = alu_result[dlts_pkg::TIME_W-1:0];
                end
            end
            dlts_pkg::S_DSP_RD:
            begin
                disp_next    = 1'b1;
                run_id_next  = ram_rdata.id;
                ins_id_next  = ram_rdata.id;
                ins_d_next   = ram_rdata.rel_delay;
                ins_per_next = ram_rdata.period;
                idx_next     = '0;
            end
            dlts_pkg::S_RM_RD:
            begin
                if (rm_more)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + IDX_W'(1);
                end
                else
                begin
                    count_next      = count_reg - CNT_W'(1);
                    head_ready_next = 1'b0;
                end
            end
            dlts_pkg::S_RM_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                idx_next  = idx_reg + IDX_W'(1);
            end
            dlts_pkg::S_INS_START:
            begin
                pos_next = '0;
                cum_next = '0;
                ram_re   = (count_reg != '0);
            end
            dlts_pkg::S_WALK_SUM:
            begin
                alu_op   = dlts_pkg::ALU_ADD;
                alu_a    = cum_reg;
                alu_b    = {1'b0, ram_rdata.rel_delay};
                sum_next = alu_result[dlts_pkg::SUM_W-1:0];
            end
            dlts_pkg::S_WALK_CMP:
            begin
                alu_op = dlts_pkg::ALU_SUB;
                alu_a  = {1'b0, ins_d_reg};
                alu_b  = sum_reg;
                if (!ins_found)
                begin
                    cum_next = sum_reg;
                    pos_next = pos_reg + IDX_W'(1);
                    if (walk_more)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = pos_reg + IDX_W'(1);
                    end
                end
            end
            dlts_pkg::S_INS_REL:
            begin
                alu_op       = dlts_pkg::ALU_SUB;
                alu_a        = {1'b0, ins_d_reg};
                alu_b        = cum_reg;
                rel_new_next = alu_result[dlts_pkg::TIME_W-1:0];
                idx_next     = count_reg[IDX_W-1:0];
            end
            dlts_pkg::S_INS_SH_RD:
            begin
                if (idx_reg > pos_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg - IDX_W'(1);
                end
            end
            dlts_pkg::S_INS_SH_WR:
            begin
                alu_op    = dlts_pkg::ALU_SUB;
                alu_a     = {1'b0, ram_rdata.rel_delay};
                alu_b     = {1'b0, rel_new_reg};
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                // the successor of the new task gives up the new task's share
                if ((idx_reg - IDX_W'(1)) == pos_reg)
                begin
                    ram_wdata.rel_delay = alu_result[dlts_pkg::TIME_W-1:0];
                end
                idx_next = idx_reg - IDX_W'(1);
            end
            dlts_pkg::S_INS_PUT:
            begin
                ram_we              = 1'b1;
                ram_waddr           = pos_reg;
                ram_wdata.id        = ins_id_reg;
                ram_wdata.rel_delay = rel_new_reg;
                ram_wdata.period    = ins_per_reg;
                count_next          = count_reg + CNT_W'(1);
                if (pos_reg == '0)
                begin
                    head_ready_next = 1'b0;
                end
            end
            dlts_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({count_reg, status_reg, run_id_reg});
                    m_tuser_next  = disp_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dlts_pkg::S_IDLE;
            count_reg      <= '0;
            head_ready_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            head_ready_reg <= head_ready_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ins_id_reg  <= ins_id_next;
        ins_d_reg   <= ins_d_next;
        ins_per_reg <= ins_per_next;
        cum_reg     <= cum_next;
        sum_reg     <= sum_next;
        rel_new_reg <= rel_new_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        disp_reg    <= disp_next;
        run_id_reg  <= run_id_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in progress");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("task count above list size");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[ST_LSB+1:ST_LSB] == dlts_pkg::ST_FULL
        |-> m_tdata[CNT_LSB+CNT_W-1:CNT_LSB] == MAX_CNT)
        else $error("add refused while list not full");

    a_dispatch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[ST_LSB+1:ST_LSB] == dlts_pkg::ST_OK)
        else $error("dispatched word carries an error status");

endmodule
